@@ hw/rtl/qstm_pkg.sv @@
// Shared types and fixed-point constants for the quaternion/scale/translate matrix block.
package qstm_pkg;

   localparam int QuatW      = 16;
   localparam int ScaleW     = 16;
   localparam int PosW       = 32;
   localparam int MatW       = 32;
   localparam int ProdW      = 2 * QuatW;
   localparam int TermW      = ProdW + 2;
   localparam int ScaledW    = TermW + ScaleW;
   localparam int RoundShift = 20;
   localparam int NumEntries = 9;
   localparam int NumAxes    = 3;

   // Unity in the Q.28 format of the rotation terms.
   localparam logic signed [TermW-1:0] OneQ28 = TermW'(1) << 28;
   // Half of one output LSB, added before the floor shift.
   localparam logic signed [ScaledW-1:0] RoundBias = ScaledW'(1) << (RoundShift - 1);

   typedef struct packed {
      logic signed [QuatW-1:0]  quat_x;
      logic signed [QuatW-1:0]  quat_y;
      logic signed [QuatW-1:0]  quat_z;
      logic signed [QuatW-1:0]  quat_w;
      logic signed [ScaleW-1:0] scale_x;
      logic signed [ScaleW-1:0] scale_y;
      logic signed [ScaleW-1:0] scale_z;
      logic signed [PosW-1:0]   pos_x;
      logic signed [PosW-1:0]   pos_y;
      logic signed [PosW-1:0]   pos_z;
   } qstm_req_type;

   typedef struct packed {
      logic signed [MatW-1:0] m00;
      logic signed [MatW-1:0] m01;
      logic signed [MatW-1:0] m02;
      logic signed [MatW-1:0] m10;
      logic signed [MatW-1:0] m11;
      logic signed [MatW-1:0] m12;
      logic signed [MatW-1:0] m20;
      logic signed [MatW-1:0] m21;
      logic signed [MatW-1:0] m22;
      logic signed [PosW-1:0] trans_x;
      logic signed [PosW-1:0] trans_y;
      logic signed [PosW-1:0] trans_z;
   } qstm_rsp_type;

endpackage

@@ hw/rtl/quat_scale_translate_to_matrix.sv @@
// Top level: four-stage pipeline turning a quaternion, scale and position into a model matrix.
module quat_scale_translate_to_matrix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  qstm_pkg::qstm_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output qstm_pkg::qstm_rsp_type rsp_data
);
   // This block takes one word per cycle while it is not stalled, each holding a rotation
   // quaternion (Q2.14), a per-axis scale (Q8.8) and a position (Q16.16), and returns one
   // word holding the upper three rows of the translate * rotate * scale model matrix. In
   // the pipeline, stage one forms the nine quaternion products, stage two builds the
   // doubled rotation terms in Q.28, stage three multiplies each term by its column's scale,
   // and stage four rounds to nearest (ties toward plus infinity) into Q16.16 and holds the
   // result word. Throughput is one word per cycle while the result channel does not stall,
   // set by the combinational multipliers of stages one and three. Every stage has its own
   // valid bit and only holds when the stage after it is full and holding, so empty slots
   // close up under a stalled result channel and the input is stalled only when all four
   // stages are full. The position passes through untouched. The quaternion is used as given,
   // with no normalization. The rounded entries cannot exceed 28 significant bits, so the
   // Q16.16 saturation limits are never reached and the result is simply sign-extended. There
   // is no configuration and no state beyond the pipeline itself.
   import qstm_pkg::*;

   // Handshake: a stage may load when it is empty or when its content moves on.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready  = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff  <= req_valid;
         if (s2_ready) s2_valid_ff  <= s1_valid_ff;
         if (s3_ready) s3_valid_ff  <= s2_valid_ff;
         if (s4_ready) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Stage one: the nine quaternion products, each exact in 32 bits.
   logic signed [ProdW-1:0]  s1_xx_in, s1_yy_in, s1_zz_in, s1_xy_in, s1_xz_in;
   logic signed [ProdW-1:0]  s1_yz_in, s1_wx_in, s1_wy_in, s1_wz_in;
   logic signed [ProdW-1:0]  s1_xx_ff, s1_yy_ff, s1_zz_ff, s1_xy_ff, s1_xz_ff;
   logic signed [ProdW-1:0]  s1_yz_ff, s1_wx_ff, s1_wy_ff, s1_wz_ff;
   logic signed [ScaleW-1:0] s1_scale_ff [NumAxes];
   logic signed [PosW-1:0]   s1_pos_ff   [NumAxes];

   always_comb begin
      s1_xx_in = ProdW'(req_data.quat_x) * ProdW'(req_data.quat_x);
      s1_yy_in = ProdW'(req_data.quat_y) * ProdW'(req_data.quat_y);
      s1_zz_in = ProdW'(req_data.quat_z) * ProdW'(req_data.quat_z);
      s1_xy_in = ProdW'(req_data.quat_x) * ProdW'(req_data.quat_y);
      s1_xz_in = ProdW'(req_data.quat_x) * ProdW'(req_data.quat_z);
      s1_yz_in = ProdW'(req_data.quat_y) * ProdW'(req_data.quat_z);
      s1_wx_in = ProdW'(req_data.quat_w) * ProdW'(req_data.quat_x);
      s1_wy_in = ProdW'(req_data.quat_w) * ProdW'(req_data.quat_y);
      s1_wz_in = ProdW'(req_data.quat_w) * ProdW'(req_data.quat_z);
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_xx_ff       <= s1_xx_in;
         s1_yy_ff       <= s1_yy_in;
         s1_zz_ff       <= s1_zz_in;
         s1_xy_ff       <= s1_xy_in;
         s1_xz_ff       <= s1_xz_in;
         s1_yz_ff       <= s1_yz_in;
         s1_wx_ff       <= s1_wx_in;
         s1_wy_ff       <= s1_wy_in;
         s1_wz_ff       <= s1_wz_in;
         s1_scale_ff[0] <= req_data.scale_x;
         s1_scale_ff[1] <= req_data.scale_y;
         s1_scale_ff[2] <= req_data.scale_z;
         s1_pos_ff[0]   <= req_data.pos_x;
         s1_pos_ff[1]   <= req_data.pos_y;
         s1_pos_ff[2]   <= req_data.pos_z;
      end
   end

   // Stage two: doubled rotation terms in Q.28. Entries run column by column, so entry k
   // belongs to column k / 3 and takes that column's scale.
   logic signed [TermW-1:0]  s2_term_in [NumEntries];
   logic signed [TermW-1:0]  s2_term_ff [NumEntries];
   logic signed [ScaleW-1:0] s2_scale_ff [NumAxes];
   logic signed [PosW-1:0]   s2_pos_ff   [NumAxes];

   always_comb begin
      s2_term_in[0] = OneQ28 - ((TermW'(s1_yy_ff) + TermW'(s1_zz_ff)) <<< 1);
      s2_term_in[1] = (TermW'(s1_xy_ff) + TermW'(s1_wz_ff)) <<< 1;
      s2_term_in[2] = (TermW'(s1_xz_ff) - TermW'(s1_wy_ff)) <<< 1;
      s2_term_in[3] = (TermW'(s1_xy_ff) - TermW'(s1_wz_ff)) <<< 1;
      s2_term_in[4] = OneQ28 - ((TermW'(s1_xx_ff) + TermW'(s1_zz_ff)) <<< 1);
      s2_term_in[5] = (TermW'(s1_yz_ff) + TermW'(s1_wx_ff)) <<< 1;
      s2_term_in[6] = (TermW'(s1_xz_ff) + TermW'(s1_wy_ff)) <<< 1;
      s2_term_in[7] = (TermW'(s1_yz_ff) - TermW'(s1_wx_ff)) <<< 1;
      s2_term_in[8] = OneQ28 - ((TermW'(s1_xx_ff) + TermW'(s1_yy_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_term_ff  <= s2_term_in;
         s2_scale_ff <= s1_scale_ff;
         s2_pos_ff   <= s1_pos_ff;
      end
   end

   // Stage three: term times scale, exact in Q.36.
   logic signed [ScaledW-1:0] s3_scaled_in [NumEntries];
   logic signed [ScaledW-1:0] s3_scaled_ff [NumEntries];
   logic signed [PosW-1:0]    s3_pos_ff    [NumAxes];

   for (genvar k = 0; k < NumEntries; k++) begin : g_scale
      localparam int Col = k / NumAxes;
      assign s3_scaled_in[k] = ScaledW'(s2_term_ff[k]) * ScaledW'(s2_scale_ff[Col]);
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_scaled_ff <= s3_scaled_in;
         s3_pos_ff    <= s2_pos_ff;
      end
   end

   // Stage four: round to nearest with ties upward, then floor-shift into Q16.16.
   logic signed [ScaledW-1:0] s4_biased [NumEntries];
   logic signed [MatW-1:0]    s4_entry  [NumEntries];
   qstm_rsp_type              rsp_data_in;
   qstm_rsp_type              rsp_data_ff;

   for (genvar k = 0; k < NumEntries; k++) begin : g_round
      assign s4_biased[k] = s3_scaled_ff[k] + RoundBias;
      assign s4_entry[k]  = MatW'($signed(s4_biased[k][ScaledW-1:RoundShift]));
   end

   always_comb begin
      rsp_data_in.m00     = s4_entry[0];
      rsp_data_in.m01     = s4_entry[1];
      rsp_data_in.m02     = s4_entry[2];
      rsp_data_in.m10     = s4_entry[3];
      rsp_data_in.m11     = s4_entry[4];
      rsp_data_in.m12     = s4_entry[5];
      rsp_data_in.m20     = s4_entry[6];
      rsp_data_in.m21     = s4_entry[7];
      rsp_data_in.m22     = s4_entry[8];
      rsp_data_in.trans_x = s3_pos_ff[0];
      rsp_data_in.trans_y = s3_pos_ff[1];
      rsp_data_in.trans_z = s3_pos_ff[2];
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

@@ hw/rtl/qstm_checker.sv @@
// Port-level assertions for the matrix block and the bind that attaches them.
module qstm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input qstm_pkg::qstm_req_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input qstm_pkg::qstm_rsp_type rsp_data
);
   import qstm_pkg::*;

   logic req_take;
   logic rsp_flow;

   assign req_take = req_valid && !req_stall;
   assign rsp_flow = !rsp_stall;

   // Nothing is presented right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the result side flowing, an accepted word shows up once it has passed every stage.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_take ##1 rsp_flow ##1 rsp_flow ##1 rsp_flow |=> rsp_valid)
      else $error("word did not arrive after four cycles");

   // The position of that word arrives unchanged.
   a_translate: assert property (@(posedge clock) disable iff (reset)
      req_take ##1 rsp_flow ##1 rsp_flow ##1 rsp_flow |=>
         rsp_data.trans_x == $past(req_data.pos_x, 4) &&
         rsp_data.trans_y == $past(req_data.pos_y, 4) &&
         rsp_data.trans_z == $past(req_data.pos_z, 4))
      else $error("translation changed in flight");

   // A zero x scale clears the whole first column.
   a_zero_col: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.scale_x == '0) ##1 rsp_flow ##1 rsp_flow ##1 rsp_flow |=>
         rsp_data.m00 == '0 && rsp_data.m01 == '0 && rsp_data.m02 == '0)
      else $error("zero scale gave a nonzero column");

   // A stalled result word stays in place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

bind quat_scale_translate_to_matrix qstm_checker u_qstm_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for the quaternion, scale and translation to model matrix block.
`timescale 1ns / 1ps

module testbench;
   import qstm_pkg::*;

   // The block is described as a four-stage pipeline. The drain wait after the last
   // word lets any stray word still in that pipeline come out and be reported.
   localparam int DrainCycles = 16;
   // The slowest correct run is roughly 1725 words, each behind the longest idle gap and
   // the longest result stall, so this limit leaves a wide margin.
   localparam int CycleLimit  = 400000;
   localparam int RandomWords = 1700;
   localparam int MaxReports  = 10;
   localparam int MaxIdle     = 11;

   // One row of the directed table. Rows marked typed carry a result that was
   // worked out by hand. All other rows are checked against the matrix predictor.
   typedef struct {
      qstm_req_type word;
      bit           typed;
      qstm_rsp_type result;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   qstm_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b1;
   qstm_rsp_type rsp_data;

   // These travel with req_data. They are updated at the same edge, so the monitor
   // sees the typed result that belongs to the word on the bus.
   logic         word_typed = 1'b0;
   qstm_rsp_type word_result = '0;

   qstm_rsp_type matrix_q[$];
   int           error_count = 0;
   int           cycle_count = 0;
   stim_row_type directed_rows[$];

   quat_scale_translate_to_matrix u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Rounds a Q.36 product to Q16.16. A tie goes toward plus infinity. The result
   // saturates to the signed 32-bit range.
   function automatic logic signed [MatW-1:0] scaled_entry(longint term, longint scale);
      longint prod;
      longint rounded;
      prod    = term * scale + (longint'(1) <<< (RoundShift - 1));
      rounded = prod >>> RoundShift;
      if (rounded > longint'(32'sh7fffffff)) begin
         rounded = longint'(32'sh7fffffff);
      end else if (rounded < -longint'(32'sh7fffffff) - 1) begin
         rounded = -longint'(32'sh7fffffff) - 1;
      end
      return MatW'(rounded);
   endfunction

   // Builds translate * rotate * scale from the doubled quaternion products.
   // No normalization is applied. The translation is copied unchanged.
   function automatic qstm_rsp_type predict_matrix(qstm_req_type q);
      longint       x, y, z, w, sx, sy, sz, one;
      longint       xx, yy, zz, xy, xz, yz, wx, wy, wz;
      qstm_rsp_type m;
      x   = longint'(q.quat_x);
      y   = longint'(q.quat_y);
      z   = longint'(q.quat_z);
      w   = longint'(q.quat_w);
      sx  = longint'(q.scale_x);
      sy  = longint'(q.scale_y);
      sz  = longint'(q.scale_z);
      one = longint'(1) <<< 28;
      xx  = 2 * x * x;
      yy  = 2 * y * y;
      zz  = 2 * z * z;
      xy  = 2 * x * y;
      xz  = 2 * x * z;
      yz  = 2 * y * z;
      wx  = 2 * w * x;
      wy  = 2 * w * y;
      wz  = 2 * w * z;
      m.m00     = scaled_entry(one - (yy + zz), sx);
      m.m01     = scaled_entry(xy + wz, sx);
      m.m02     = scaled_entry(xz - wy, sx);
      m.m10     = scaled_entry(xy - wz, sy);
      m.m11     = scaled_entry(one - (xx + zz), sy);
      m.m12     = scaled_entry(yz + wx, sy);
      m.m20     = scaled_entry(xz + wy, sz);
      m.m21     = scaled_entry(yz - wx, sz);
      m.m22     = scaled_entry(one - (xx + yy), sz);
      m.trans_x = q.pos_x;
      m.trans_y = q.pos_y;
      m.trans_z = q.pos_z;
      return m;
   endfunction

   function automatic qstm_req_type make_word(int qx, int qy, int qz, int qw,
                                              int sx, int sy, int sz,
                                              int px, int py, int pz);
      qstm_req_type word;
      word.quat_x  = QuatW'(qx);
      word.quat_y  = QuatW'(qy);
      word.quat_z  = QuatW'(qz);
      word.quat_w  = QuatW'(qw);
      word.scale_x = ScaleW'(sx);
      word.scale_y = ScaleW'(sy);
      word.scale_z = ScaleW'(sz);
      word.pos_x   = PosW'(px);
      word.pos_y   = PosW'(py);
      word.pos_z   = PosW'(pz);
      return word;
   endfunction

   // A row whose result can be read off directly: only the diagonal is nonzero
   // and the translation is the position.
   function automatic stim_row_type diag_row(qstm_req_type word, int d0, int d1, int d2);
      stim_row_type row;
      row.word           = word;
      row.typed          = 1'b1;
      row.result         = '0;
      row.result.m00     = MatW'(d0);
      row.result.m11     = MatW'(d1);
      row.result.m22     = MatW'(d2);
      row.result.trans_x = word.pos_x;
      row.result.trans_y = word.pos_y;
      row.result.trans_z = word.pos_z;
      return row;
   endfunction

   function automatic stim_row_type predicted_row(qstm_req_type word);
      stim_row_type row;
      row.word   = word;
      row.typed  = 1'b0;
      row.result = '0;
      return row;
   endfunction

   // Idle draw shared by both sides. Every third stretch of 64 words runs with no
   // gaps at all, so that back-to-back traffic is covered as well.
   function automatic int idle_cycles(int count);
      if ((count / 64) % 3 == 2) begin
         return 0;
      end
      return $urandom_range(0, MaxIdle);
   endfunction

   // Random 16-bit field. The extremes and values near unity appear often. The
   // rest of the time the value is uniform, so every bit toggles.
   function automatic logic [15:0] pick16(logic [15:0] unity);
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return unity ^ 16'($urandom_range(0, 255));
         4: return -(unity ^ 16'($urandom_range(0, 255)));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic qstm_req_type random_word();
      qstm_req_type word;
      word.quat_x  = pick16(16'h4000);
      word.quat_y  = pick16(16'h4000);
      word.quat_z  = pick16(16'h4000);
      word.quat_w  = pick16(16'h4000);
      word.scale_x = pick16(16'h0100);
      word.scale_y = pick16(16'h0100);
      word.scale_z = pick16(16'h0100);
      word.pos_x   = pick32();
      word.pos_y   = pick32();
      word.pos_z   = pick32();
      return word;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MaxReports) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // Field by field comparison of one result word against the oldest expectation.
   // The packed struct puts m00 in the top 32 bits, so the slice index runs down.
   task automatic check_matrix(qstm_rsp_type want, qstm_rsp_type got);
      string            names[12];
      logic [11:0][31:0] want_f;
      logic [11:0][31:0] got_f;
      names  = '{"m00", "m01", "m02", "m10", "m11", "m12",
                 "m20", "m21", "m22", "trans_x", "trans_y", "trans_z"};
      want_f = want;
      got_f  = got;
      for (int i = 0; i < 12; i++) begin
         if (got_f[11-i] !== want_f[11-i]) begin
            report_error($sformatf("%s expected %0d (0x%08h) got %0d (0x%08h)", names[i],
                                   $signed(want_f[11-i]), want_f[11-i],
                                   $signed(got_f[11-i]), got_f[11-i]));
         end
      end
   endtask

   // Send one word. Valid drops for the idle gap, then rises with the payload. It
   // stays there until the block takes the word. Only one assignment to req_valid
   // happens per edge, because the next call begins at the edge that ends this one.
   task automatic send_word(qstm_req_type word, bit typed, qstm_rsp_type result, int count);
      int gap;
      gap = idle_cycles(count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= word;
      word_typed  <= typed;
      word_result <= result;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Hold the sender until every expected word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (matrix_q.size() != 0);
   endtask

   // The cycle counter and the run limit. The timeout path ends the run from here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The monitor. Values are read at the rising edge, before the nonblocking
   // updates of that edge land. A result is checked before this edge's input is
   // queued, since no word can leave in the same cycle that it enters.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (matrix_q.size() == 0) begin
               report_error("result word with no expectation waiting");
            end else begin
               check_matrix(matrix_q.pop_front(), rsp_data);
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            matrix_q.push_back(word_typed ? word_result : predict_matrix(req_data));
         end
      end
   end

   // The result side. It stalls for a random count before each word, with the
   // same no-idle stretches as the sender. Then it waits with stall low until a
   // word is taken.
   initial begin
      int taken;
      int hold;
      taken = 0;
      forever begin
         hold = idle_cycles(taken);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
         taken++;
      end
   end

   // Stimulus. First the directed table, then a pause until the pipeline is empty,
   // then the random words with one more full drain halfway through.
   initial begin
      qstm_rsp_type no_result;
      no_result = '0;

      // Identity rotation at unit scale gives 1.0 on the diagonal.
      directed_rows.push_back(diag_row(make_word(0, 0, 0, 16384, 256, 256, 256, 0, 0, 0),
                                       65536, 65536, 65536));
      // A zero quaternion leaves the constant one times the scale. The largest
      // scale is used here, and two of the positions sit at their extremes.
      directed_rows.push_back(diag_row(make_word(0, 0, 0, 0, 32767, 32767, 32767,
                                                 32'h7fffffff, 32'h80000000, -1),
                                       8388352, 8388352, 8388352));
      directed_rows.push_back(diag_row(make_word(0, 0, 0, 0, -32768, -32768, -32768,
                                                 32'h80000000, 32'h7fffffff, 1),
                                       -8388608, -8388608, -8388608));
      directed_rows.push_back(diag_row(make_word(0, 0, 0, 0, 0, 0, 0,
                                                 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f),
                                       0, 0, 0));
      // Half turn about x flips the y and z axes.
      directed_rows.push_back(diag_row(make_word(16384, 0, 0, 0, 256, 256, 256, 65536, 0, 0),
                                       65536, -65536, -65536));
      directed_rows.push_back(diag_row(make_word(0, 0, 0, 16384, -256, 512, 128, 0, -1, 0),
                                       -65536, 131072, 32768));
      // The largest quaternion products. They come close to the widest rotation
      // terms but do not pass beyond the saturation bounds.
      directed_rows.push_back(predicted_row(make_word(-32768, -32768, -32768, -32768,
                                                      32767, -32768, 32767, 0, 0, 0)));
      directed_rows.push_back(predicted_row(make_word(32767, 32767, 32767, 32767,
                                                      -32768, 32767, -32768, -1, -1, -1)));
      directed_rows.push_back(predicted_row(make_word(-32768, 32767, -32768, 32767,
                                                      32767, 32767, 32767, 1, 2, 3)));
      directed_rows.push_back(predicted_row(make_word(32767, -32768, 32767, -32768,
                                                      -32768, -32768, -32768, 7, 8, 9)));
      // An unnormalized quaternion near length two is used as given.
      directed_rows.push_back(predicted_row(make_word(0, 0, 0, 32767, 256, 256, 256,
                                                      0, 0, 0)));
      // Quarter turns about each axis, where the half-unit products round.
      directed_rows.push_back(predicted_row(make_word(0, 0, 11585, 11585, 256, 256, 256,
                                                      100, 200, 300)));
      directed_rows.push_back(predicted_row(make_word(11585, 0, 0, 11585, 300, -300, 1,
                                                      0, 0, 0)));
      directed_rows.push_back(predicted_row(make_word(0, -11585, 0, 11585, -1, 1, 32767,
                                                      0, 0, 0)));
      // The smallest nonzero components and scales, and small odd scales on larger
      // components, exercise the rounding and its signs.
      directed_rows.push_back(predicted_row(make_word(1, 1, 1, 1, 1, 1, 1, 0, 0, 0)));
      directed_rows.push_back(predicted_row(make_word(-1, 1, -1, 1, -1, -1, -1, 0, 0, 0)));
      directed_rows.push_back(predicted_row(make_word(1, -1, 1, -1, 1, -1, 1, 0, 0, 0)));
      directed_rows.push_back(predicted_row(make_word(8192, 8192, 8192, 8192, 1, 3, 5,
                                                      0, 0, 0)));
      directed_rows.push_back(predicted_row(make_word(-8192, 8192, -8192, 8192, -1, -3, -5,
                                                      0, 0, 0)));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, directed_rows[i].typed,
                   directed_rows[i].result, i);
      end
      drain_results();

      for (int n = 0; n < RandomWords; n++) begin
         if (n == RandomWords / 2) begin
            drain_results();
         end
         send_word(random_word(), 1'b0, no_result, n);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (matrix_q.size() != 0);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/qstm_pkg.sv
hw/rtl/quat_scale_translate_to_matrix.sv
hw/rtl/qstm_checker.sv
test/testbench.sv
